### design/stag_pkg.sv
package stag_pkg;

   localparam int IN_DATA_W  = 56;
   localparam int OUT_DATA_W = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_FLIP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_UPPER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_LIMIT_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_LIMIT_Y = 2'd3;

   localparam logic [9:0] MIRROR_LIMIT_X_RESET = 10'd248;
   localparam logic [9:0] MIRROR_LIMIT_Y_RESET = 10'd216;

   localparam logic [1:0] SIZE_2X2  = 2'd0;
   localparam logic [1:0] SIZE_4X4  = 2'd1;
   localparam logic [1:0] SIZE_2X32 = 2'd2;
   localparam logic [1:0] SIZE_4X32 = 2'd3;

   localparam logic [8:0] YBASE_SMALL = 9'h100;
   localparam logic [8:0] YBASE_2X32  = 9'h130;
   localparam logic [8:0] YBASE_4X32  = 9'h120;

   localparam logic [8:0] HEIGHT_PX_2  = 9'd16;
   localparam logic [8:0] HEIGHT_PX_4  = 9'd32;
   localparam logic [8:0] HEIGHT_PX_32 = 9'd256;

   localparam logic signed [11:0] SCREEN_X_MAX = 12'sd1023;
   localparam logic [4:0]         COLOR_OFFSET_BANK = 5'd16;

   typedef struct packed {
      logic              present;
      logic [4:0]        page;
      logic [4:0]        col_part;
      logic [4:0]        row_part;
      logic signed [9:0] pos_x;
      logic [7:0]        pos_y;
      logic              sprite_flip;
      logic [3:0]        code_bank;
   } decode_type;

   typedef struct packed {
      logic               present;
      logic [14:0]        tile_address;
      logic signed [11:0] pos_x;
      logic signed [10:0] pos_y;
      logic               toggle_flip_x;
      logic               toggle_flip_y;
      logic [3:0]         code_bank;
      logic [4:0]         color_offset;
   } mirror_type;

endpackage

### design/sprite_tile_address_generator_unit.sv
// Registered stages, in order: decode, mirror, clamp; the clamp register drives rsp_tvalid.
// Throughput: one item per cycle; each stage advances when the one after it is free,
// and the output register takes a new item in the cycle its old item is taken.
// Reset (synchronous, active high) empties all stages and loads the register defaults:
// screen flip 0, upper palette 0, mirror limits 248 and 216.
module sprite_tile_address_generator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sprite_word_pos_y, sprite_word_pos_x, sprite_word_size, tile_row, tile_col
   input  logic [stag_pkg::IN_DATA_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tile_address, screen_x, screen_y, toggle_flip_x, toggle_flip_y, code_bank,
   // color_offset
   output logic [stag_pkg::OUT_DATA_W-1:0]      rsp_tdata,
   // tile_present
   output logic                                 rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [stag_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stag_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic       screen_flip_ff;
   logic       palette_upper_ff;
   logic [9:0] limit_x_ff;
   logic [9:0] limit_y_ff;

   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                   s1_ready, s2_ready, s3_ready;
   stag_pkg::decode_type   s1_ff, s1_in;
   stag_pkg::mirror_type   s2_ff, s2_in;
   logic [stag_pkg::OUT_DATA_W-1:0] s3_data_ff, s3_data_in;
   logic                   s3_present_ff, s3_present_in;

   logic [15:0] word_y, word_x, word_size;
   logic [4:0]  row;
   logic [1:0]  col;
   logic [1:0]  size_code;
   logic        wide, tall, present;
   logic [8:0]  ybase, height_px;
   logic [7:0]  y_offset;
   logic        sprite_flip;
   logic [1:0]  tx;
   logic [4:0]  src_col;

   logic signed [10:0] clamp_x;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_flip_ff   <= 1'b0;
         palette_upper_ff <= 1'b0;
         limit_x_ff       <= stag_pkg::MIRROR_LIMIT_X_RESET;
         limit_y_ff       <= stag_pkg::MIRROR_LIMIT_Y_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            stag_pkg::CSR_SCREEN_FLIP:    screen_flip_ff   <= csr_data[0];
            stag_pkg::CSR_PALETTE_UPPER:  palette_upper_ff <= csr_data[0];
            stag_pkg::CSR_MIRROR_LIMIT_X: limit_x_ff       <= csr_data;
            stag_pkg::CSR_MIRROR_LIMIT_Y: limit_y_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // decode
   always_comb begin
      word_y    = req_tdata[15:0];
      word_x    = req_tdata[31:16];
      word_size = req_tdata[47:32];
      row       = req_tdata[52:48];
      col       = req_tdata[54:53];
      size_code = word_size[7:6];
      wide      = size_code[0];
      tall      = size_code[1];
      case (size_code)
         stag_pkg::SIZE_2X2: begin
            ybase     = stag_pkg::YBASE_SMALL;
            height_px = stag_pkg::HEIGHT_PX_2;
         end
         stag_pkg::SIZE_4X4: begin
            ybase     = stag_pkg::YBASE_SMALL;
            height_px = stag_pkg::HEIGHT_PX_4;
         end
         stag_pkg::SIZE_2X32: begin
            ybase     = stag_pkg::YBASE_2X32;
            height_px = stag_pkg::HEIGHT_PX_32;
         end
         default: begin
            ybase     = stag_pkg::YBASE_4X32;
            height_px = stag_pkg::HEIGHT_PX_32;
         end
      endcase
      y_offset = ybase[7:0] - height_px[7:0];
      present  = (wide || !col[1])
               && (tall || (wide ? (row[4:2] == 3'd0) : (row[4:1] == 4'd0)));
      sprite_flip = wide & word_y[8];
      tx          = sprite_flip ? ~col : col;
      src_col     = {word_y[11:9], word_y[8] & ~wide, 1'b0};

      s1_in.present     = present;
      s1_in.page        = {word_x[9], word_y[15:12]};
      s1_in.col_part    = src_col + {3'b000, tx};
      s1_in.row_part    = {word_size[3:0], 1'b0} + row;
      s1_in.pos_x       = $signed({word_x[8], word_x[8:0]}) + $signed({3'b000, col, 3'b000});
      s1_in.pos_y       = y_offset - word_y[7:0] + {row, 3'b000};
      s1_in.sprite_flip = sprite_flip;
      s1_in.code_bank   = word_x[15:12];
   end

   // mirror
   always_comb begin
      s2_in.present       = s1_ff.present;
      s2_in.tile_address  = {s1_ff.page, s1_ff.col_part, s1_ff.row_part};
      s2_in.pos_x         = screen_flip_ff
                          ? $signed({2'b00, limit_x_ff}) - 12'(s1_ff.pos_x)
                          : 12'(s1_ff.pos_x);
      s2_in.pos_y         = screen_flip_ff
                          ? $signed({1'b0, limit_y_ff}) - $signed({3'b000, s1_ff.pos_y})
                          : $signed({3'b000, s1_ff.pos_y});
      s2_in.toggle_flip_x = s1_ff.sprite_flip ^ screen_flip_ff;
      s2_in.toggle_flip_y = screen_flip_ff;
      s2_in.code_bank     = s1_ff.code_bank;
      s2_in.color_offset  = palette_upper_ff ? stag_pkg::COLOR_OFFSET_BANK : 5'd0;
   end

   // clamp and zero tiles outside the sprite
   always_comb begin
      clamp_x = (s2_ff.pos_x > stag_pkg::SCREEN_X_MAX)
              ? 11'(stag_pkg::SCREEN_X_MAX) : s2_ff.pos_x[10:0];
      s3_present_in = s2_ff.present;
      if (s2_ff.present) begin
         s3_data_in = {s2_ff.color_offset, s2_ff.code_bank, s2_ff.toggle_flip_y,
                       s2_ff.toggle_flip_x, s2_ff.pos_y, clamp_x, s2_ff.tile_address};
      end else begin
         s3_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_tvalid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) s1_ff <= s1_in;
      if (s2_ready && s1_valid_ff) s2_ff <= s2_in;
      if (s3_ready && s2_valid_ff) begin
         s3_data_ff    <= s3_data_in;
         s3_present_ff <= s3_present_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_data_ff;
   assign rsp_tuser  = s3_present_ff;

endmodule

### design/stag_checker.sv
module stag_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [stag_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   input logic                               rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp item shown right after reset");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("tile outside sprite carries nonzero fields");

   a_color_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[46:43] == 4'd0)
      else $error("color offset is neither 0 nor 16");

endmodule

bind sprite_tile_address_generator_unit stag_checker u_stag_checker (.*);

### tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        present;
      logic [14:0] tile_address;
      logic [10:0] screen_x;
      logic [10:0] screen_y;
      logic        toggle_flip_x;
      logic        toggle_flip_y;
      logic [3:0]  code_bank;
      logic [4:0]  color_offset;
   } tile_result_type;

   class tile_scoreboard;
      logic            screen_flip;
      logic            palette_upper;
      logic [9:0]      limit_x;
      logic [9:0]      limit_y;
      tile_result_type tile_results_due[$];
      int              errors;

      function new();
         screen_flip   = 1'b0;
         palette_upper = 1'b0;
         limit_x       = stag_pkg::MIRROR_LIMIT_X_RESET;
         limit_y       = stag_pkg::MIRROR_LIMIT_Y_RESET;
         errors        = 0;
      endfunction

      function void write_reg(logic [stag_pkg::CSR_IDX_W-1:0] idx,
                              logic [stag_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            stag_pkg::CSR_SCREEN_FLIP:    screen_flip   = val[0];
            stag_pkg::CSR_PALETTE_UPPER:  palette_upper = val[0];
            stag_pkg::CSR_MIRROR_LIMIT_X: limit_x       = val;
            stag_pkg::CSR_MIRROR_LIMIT_Y: limit_y       = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return tile_results_due.size();
      endfunction

      function void note_request(logic [stag_pkg::IN_DATA_W-1:0] d);
         logic [15:0]     wy;
         logic [15:0]     wx;
         logic [15:0]     ws;
         logic [4:0]      row;
         logic [1:0]      col;
         logic            sflip;
         int              width;
         int              height;
         int              ybase;
         int              page;
         int              scol;
         int              srow;
         int              tx;
         int              addr;
         int              sx;
         int              sy;
         tile_result_type r;
         wy  = d[15:0];
         wx  = d[31:16];
         ws  = d[47:32];
         row = d[52:48];
         col = d[54:53];
         r   = '0;
         case (ws[7:6])
            stag_pkg::SIZE_2X2: begin
               width = 2; height = 2; ybase = int'(stag_pkg::YBASE_SMALL);
            end
            stag_pkg::SIZE_4X4: begin
               width = 4; height = 4; ybase = int'(stag_pkg::YBASE_SMALL);
            end
            stag_pkg::SIZE_2X32: begin
               width = 2; height = 32; ybase = int'(stag_pkg::YBASE_2X32);
            end
            default: begin
               width = 4; height = 32; ybase = int'(stag_pkg::YBASE_4X32);
            end
         endcase
         if (int'(col) < width && int'(row) < height) begin
            page  = int'(wy[15:12]) + (wx[9] ? 16 : 0);
            scol  = int'(wy[11:8]) * 2;
            srow  = int'(ws[3:0]) * 2;
            sflip = 1'b0;
            if (width == 4) begin
               sflip = wy[8];
               scol  = scol & ~2;
            end
            tx   = sflip ? (width - 1 - int'(col)) : int'(col);
            addr = page * 1024 + ((scol + tx) & 31) * 32 + ((srow + int'(row)) & 31);
            sx   = int'(wx[7:0]) - (wx[8] ? 256 : 0) + int'(col) * 8;
            sy   = (((ybase - int'(wy[7:0]) - height * 8) & 255) + int'(row) * 8) & 255;
            if (screen_flip) begin
               sx = int'(limit_x) - sx;
               sy = int'(limit_y) - sy;
            end
            if (sx > 1023) sx = 1023;
            if (sx < -512) sx = -512;
            if (sy > 1023) sy = 1023;
            if (sy < -512) sy = -512;
            r.present       = 1'b1;
            r.tile_address  = 15'(addr);
            r.screen_x      = 11'(sx);
            r.screen_y      = 11'(sy);
            r.toggle_flip_x = sflip ^ screen_flip;
            r.toggle_flip_y = screen_flip;
            r.code_bank     = wx[15:12];
            r.color_offset  = palette_upper ? stag_pkg::COLOR_OFFSET_BANK : 5'd0;
         end
         tile_results_due.push_back(r);
      endfunction

      function void compare(string name, int want, int got);
         if (want != got) begin
            errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
         end
      endfunction

      function void check_result(logic present, logic [stag_pkg::OUT_DATA_W-1:0] d);
         tile_result_type want;
         if (tile_results_due.size() == 0) begin
            errors++;
            $error("result item with no expected item pending");
            return;
         end
         want = tile_results_due.pop_front();
         compare("tile_present", int'(want.present), int'(present));
         compare("tile_address", int'(want.tile_address), int'(d[14:0]));
         compare("screen_x", int'($signed(want.screen_x)), int'($signed(d[25:15])));
         compare("screen_y", int'($signed(want.screen_y)), int'($signed(d[36:26])));
         compare("toggle_flip_x", int'(want.toggle_flip_x), int'(d[37]));
         compare("toggle_flip_y", int'(want.toggle_flip_y), int'(d[38]));
         compare("code_bank", int'(want.code_bank), int'(d[42:39]));
         compare("color_offset", int'(want.color_offset), int'(d[47:43]));
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [stag_pkg::IN_DATA_W-1:0]  req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [stag_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [stag_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [stag_pkg::CSR_DATA_W-1:0] csr_data;

   tile_scoreboard        sb;
   bit                    quiet_run;
   int                    stall_left;

   sprite_tile_address_generator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (quiet_run)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [stag_pkg::IN_DATA_W-1:0] make_item(logic [15:0] wy,
                                                                logic [15:0] wx,
                                                                logic [15:0] ws,
                                                                logic [4:0] row,
                                                                logic [1:0] col);
      return {1'b0, col, row, ws, wx, wy};
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata);
      end
   end

   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (quiet_run) begin
            rsp_tready = 1'b1;
            stall_left = 0;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if ($urandom_range(0, 2) == 0)
               stall_left = pick_gap();
         end
      end
   end

   task automatic send_item(logic [stag_pkg::IN_DATA_W-1:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(logic [stag_pkg::CSR_IDX_W-1:0] idx,
                            logic [stag_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      req_tvalid = 1'b0;
      csr_valid  = 1'b1;
      csr_index  = idx;
      csr_data   = val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic configure(int phase);
      logic [9:0] lx;
      logic [9:0] ly;
      case (phase)
         1: begin
            write_reg(stag_pkg::CSR_SCREEN_FLIP, 10'h3ff);
            write_reg(stag_pkg::CSR_PALETTE_UPPER, 10'd1);
            write_reg(stag_pkg::CSR_MIRROR_LIMIT_X, 10'd1023);
            write_reg(stag_pkg::CSR_MIRROR_LIMIT_Y, 10'd1023);
         end
         2: begin
            write_reg(stag_pkg::CSR_MIRROR_LIMIT_Y, 10'd0);
            write_reg(stag_pkg::CSR_MIRROR_LIMIT_X, 10'd0);
            write_reg(stag_pkg::CSR_PALETTE_UPPER, 10'h3fe);
            write_reg(stag_pkg::CSR_SCREEN_FLIP, 10'd1);
         end
         3: begin
            write_reg(stag_pkg::CSR_SCREEN_FLIP, 10'h2aa);
            write_reg(stag_pkg::CSR_PALETTE_UPPER, 10'h155);
            write_reg(stag_pkg::CSR_MIRROR_LIMIT_X, stag_pkg::MIRROR_LIMIT_X_RESET);
            write_reg(stag_pkg::CSR_MIRROR_LIMIT_Y, stag_pkg::MIRROR_LIMIT_Y_RESET);
         end
         default: begin
            lx = ($urandom_range(0, 3) == 0) ? 10'd1023 : 10'($urandom);
            ly = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom);
            write_reg(stag_pkg::CSR_SCREEN_FLIP, 10'($urandom));
            write_reg(stag_pkg::CSR_PALETTE_UPPER, 10'($urandom));
            write_reg(stag_pkg::CSR_MIRROR_LIMIT_X, lx);
            write_reg(stag_pkg::CSR_MIRROR_LIMIT_Y, ly);
         end
      endcase
   endtask

   task automatic send_random_item();
      logic [15:0] ws;
      logic [4:0]  row;
      logic [1:0]  col;
      int          width;
      int          height;
      ws     = 16'($urandom);
      width  = ws[6] ? 4 : 2;
      height = (ws[7:6] == stag_pkg::SIZE_2X2) ? 2 :
               (ws[7:6] == stag_pkg::SIZE_4X4) ? 4 : 32;
      if ($urandom_range(0, 99) < 85) begin
         row = 5'($urandom_range(0, height - 1));
         col = 2'($urandom_range(0, width - 1));
      end else begin
         row = 5'($urandom);
         col = 2'($urandom);
      end
      send_item(make_item(16'($urandom), 16'($urandom), ws, row, col));
   endtask

   task automatic send_directed();
      send_item(make_item(16'h0000, 16'h0000, 16'h0000, 5'd0, 2'd0));
      send_item(make_item(16'hffff, 16'hffff, 16'hffff, 5'd31, 2'd3));
      send_item(make_item(16'h1234, 16'h00ff, 16'h0000, 5'd1, 2'd1));
      send_item(make_item(16'h1234, 16'h0100, 16'h0000, 5'd2, 2'd0));
      send_item(make_item(16'h1234, 16'h01ff, 16'h0000, 5'd0, 2'd2));
      send_item(make_item(16'h51ff, 16'h3300, 16'h004f, 5'd3, 2'd3));
      send_item(make_item(16'h5000, 16'h3300, 16'h004f, 5'd3, 2'd0));
      send_item(make_item(16'h5100, 16'h3300, 16'h004f, 5'd4, 2'd1));
      send_item(make_item(16'hafff, 16'hc2ff, 16'h008f, 5'd31, 2'd1));
      send_item(make_item(16'hafff, 16'hc2ff, 16'h008f, 5'd31, 2'd2));
      send_item(make_item(16'h7f80, 16'h5200, 16'h00cf, 5'd31, 2'd0));
      send_item(make_item(16'h7e80, 16'h5300, 16'h00c0, 5'd0, 2'd3));
      send_item(make_item(16'hff00, 16'hf2ff, 16'hff3f, 5'd1, 2'd1));
      send_item(make_item(16'h0fff, 16'h0dff, 16'h00ff, 5'd16, 2'd2));
      send_item(make_item(16'h00ff, 16'h0000, 16'h0040, 5'd31, 2'd3));
      send_item(make_item(16'h0001, 16'h0180, 16'h0080, 5'd0, 2'd3));
      send_item(make_item(16'h0001, 16'h0180, 16'h0080, 5'd2, 2'd1));
      send_item(make_item(16'h8800, 16'hfdff, 16'h00c5, 5'd12, 2'd2));
      send_item(make_item(16'h0000, 16'h0000, 16'h0000, 5'd31, 2'd3));
      send_item(make_item(16'h0000, 16'h0000, 16'h0000, 5'd1, 2'd1));
   endtask

   initial begin
      int phase;
      int n;
      int quiet_at;
      sb         = new();
      quiet_run  = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (phase = 0; phase < 8; phase++) begin
         if (phase > 0)
            configure(phase);
         if (phase == 0)
            send_directed();
         if (phase == 1) begin
            send_item(make_item(16'h0000, 16'h0100, 16'h0000, 5'd0, 2'd0));
            send_item(make_item(16'h0000, 16'h0101, 16'h00c0, 5'd31, 2'd3));
            send_item(make_item(16'h00ff, 16'h0000, 16'h0000, 5'd1, 2'd1));
         end
         quiet_at = $urandom_range(0, 150);
         for (n = 0; n < 180; n++) begin
            quiet_run = (n >= quiet_at && n < quiet_at + 25);
            send_random_item();
         end
         quiet_run = 1'b0;
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
design/stag_pkg.sv
design/sprite_tile_address_generator_unit.sv
design/stag_checker.sv
tb/sv/tb.sv
